[hdl/rzpt_pkg.sv]
// shared types, widths and constants of the rolling z-score pair trader
`timescale 1ns / 1ps

package rzpt_pkg;

   // window storage
   localparam int MAX_WINDOW = 64;
   localparam int RING_AW    = $clog2(MAX_WINDOW);

   // field and state widths
   localparam int PRICE_W   = 24;
   localparam int SPREAD_W  = 25;
   localparam int WIN_W     = 7;
   localparam int LIMIT_W   = 10;
   localparam int THR_W     = 16;
   localparam int TOTAL_W   = 32;
   localparam int SQUARE_W  = 55;
   localparam int UNITS_W   = 11;
   localparam int PROFIT_W  = 48;
   localparam int ORDER_W   = 2;

   // shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;

   // stream and register port widths
   localparam int REQ_DATA_W = 2 * PRICE_W;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 16;

   // register indexes
   localparam logic [CSR_AW-1:0] REG_WINDOW    = 2'd0;
   localparam logic [CSR_AW-1:0] REG_LIMIT     = 2'd1;
   localparam logic [CSR_AW-1:0] REG_THRESHOLD = 2'd2;

   // register reset values
   localparam logic [WIN_W-1:0]   WINDOW_RESET    = 7'd20;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 10'd5;
   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 16'd512;

   // profit clip limits
   localparam logic signed [PROFIT_W-1:0] PROFIT_MAX = {1'b0, {(PROFIT_W-1){1'b1}}};
   localparam logic signed [PROFIT_W-1:0] PROFIT_MIN = {1'b1, {(PROFIT_W-1){1'b0}}};

   typedef enum logic [ORDER_W-1:0] {
      ORDER_NONE = 2'd0,
      ORDER_SELL = 2'd1,
      ORDER_BUY  = 2'd2
   } order_type;

   // settings handed from the register file to the core
   typedef struct packed {
      logic [WIN_W-1:0]   window;     // effective window, 1 to MAX_WINDOW
      logic [LIMIT_W-1:0] limit;
      logic [THR_W-1:0]   threshold;
      logic               clear;      // window register written this cycle
   } cfg_type;

   // one finished tick
   typedef struct packed {
      order_type                   order;
      logic signed [UNITS_W-1:0]   held_units;
      logic signed [PROFIT_W-1:0]  profit;
      logic                        active;
      logic                        profit_saturated;
   } result_type;

endpackage

[hdl/rzpt_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module rzpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

[hdl/rzpt_mul.sv]
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps

module rzpt_mul (
   input  logic                        clock,
   input  logic [rzpt_pkg::MUL_W-1:0]  op_a,
   input  logic [rzpt_pkg::MUL_W-1:0]  op_b,
   output logic [rzpt_pkg::PROD_W-1:0] product_ff
);

   import rzpt_pkg::*;

   logic [PROD_W-1:0] product_in;

   // one full product per cycle
   assign product_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

[hdl/rzpt_core.sv]
// tick sequencer: window upkeep, z-score test, trading and profit on a shared multiplier
`timescale 1ns / 1ps

module rzpt_core (
   input  logic                         clock,
   input  logic                         reset,
   input  rzpt_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [rzpt_pkg::PRICE_W-1:0] price_a,
   input  logic [rzpt_pkg::PRICE_W-1:0] price_b,
   input  logic                         last_tick,
   output logic                         res_valid,
   input  logic                         res_ready,
   output rzpt_pkg::result_type         result
);

   import rzpt_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_NEW,
      ST_SQ_OLD,
      ST_N_SPREAD,
      ST_SUM_SQ,
      ST_N_SQ_LO,
      ST_N_SQ_HI,
      ST_D_SQ,
      ST_T_SQ,
      ST_V_LO,
      ST_V_HI,
      ST_RHS,
      ST_COMPARE,
      ST_TRADE,
      ST_CLOSE_MUL,
      ST_CLOSE,
      ST_DONE
   } state_type;

   // control and architectural state
   state_type                    state_ff, state_in;
   logic [RING_AW-1:0]           ptr_ff, ptr_in;
   logic signed [TOTAL_W-1:0]    tot_ff, tot_in;
   logic [SQUARE_W-1:0]          sq_ff, sq_in;
   logic [WIN_W-1:0]             ticks_ff, ticks_in;
   logic signed [UNITS_W-1:0]    units_ff, units_in;
   logic signed [PROFIT_W-1:0]   cash_ff, cash_in;
   logic                         clip_ff, clip_in;
   order_type                    order_ff, order_in;

   // per-tick working registers
   logic signed [SPREAD_W-1:0]   spread_ff, spread_in;
   logic signed [SPREAD_W-1:0]   old_ff, old_in;
   logic                         last_ff, last_in;
   logic                         active_ff, active_in;
   logic signed [TOTAL_W:0]      d_ff, d_in;
   logic [PROD_W-1:0]            sm2_ff, sm2_in;
   logic [PROD_W-1:0]            v_ff, v_in;
   logic [PROD_W-1:0]            lhs_ff, lhs_in;
   logic [MUL_W-1:0]             t2_ff, t2_in;
   logic [PROD_W+MUL_W-1:0]      rhs_ff, rhs_in;
   logic                         beyond_ff, beyond_in;

   // multiplier and ring ports
   logic [MUL_W-1:0]             op_a;
   logic [MUL_W-1:0]             op_b;
   logic [PROD_W-1:0]            prod;
   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [RING_AW-1:0]           ram_rd_addr;
   logic [SPREAD_W-1:0]          ram_rd_data;

   // helper values
   logic [WIN_W-1:0]             n;
   logic [MUL_W-1:0]             spread_mag;
   logic [MUL_W-1:0]             old_mag;
   logic [MUL_W-1:0]             tot_mag;
   logic [TOTAL_W:0]             d_mag;
   logic [MUL_W-1:0]             units_mag;
   logic signed [TOTAL_W+1:0]    n_spread;
   logic signed [TOTAL_W+1:0]    d_wide;
   logic [WIN_W:0]               ticks_inc;
   logic [WIN_W:0]               ticks_cap;
   logic signed [UNITS_W:0]      units_wide;
   logic signed [UNITS_W:0]      lim_wide;
   logic                         sell_ok;
   logic                         buy_ok;
   logic signed [PROFIT_W-1:0]   close_mag;
   logic signed [PROFIT_W-1:0]   close_delta;
   logic [PROFIT_W:0]            trade_sum;
   logic [PROFIT_W:0]            close_sum;
   logic signed [PROFIT_W-1:0]   trade_delta;
   logic [PROD_W+MUL_W-1:0]      lhs_wide;

   // saturating profit update, returns clip flag over the new value
   function automatic logic [PROFIT_W:0] sat_add(
      input logic signed [PROFIT_W-1:0] acc,
      input logic signed [PROFIT_W-1:0] delta
   );
      logic signed [PROFIT_W:0] sum;
      logic [PROFIT_W:0]        res;
      sum = {acc[PROFIT_W-1], acc} + {delta[PROFIT_W-1], delta};
      if (sum[PROFIT_W] != sum[PROFIT_W-1]) begin
         res = {1'b1, (sum[PROFIT_W] ? PROFIT_MIN : PROFIT_MAX)};
      end else begin
         res = {1'b0, sum[PROFIT_W-1:0]};
      end
      return res;
   endfunction

   rzpt_mul u_mul (
      .clock      (clock),
      .op_a       (op_a),
      .op_b       (op_b),
      .product_ff (prod)
   );

   rzpt_ram #(
      .WIDTH (SPREAD_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ptr_ff),
      .wr_data    (spread_ff),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   assign n = cfg.window;

   // magnitudes fed to the unsigned multiplier
   assign spread_mag = MUL_W'(spread_ff[SPREAD_W-1] ? -spread_ff : spread_ff);
   assign old_mag    = MUL_W'(old_ff[SPREAD_W-1] ? -old_ff : old_ff);
   assign tot_mag    = tot_ff[TOTAL_W-1] ? MUL_W'(-tot_ff) : MUL_W'(tot_ff);
   assign d_mag      = d_ff[TOTAL_W] ? (TOTAL_W+1)'(-d_ff) : (TOTAL_W+1)'(d_ff);
   assign units_mag  = MUL_W'(units_ff[UNITS_W-1] ? -units_ff : units_ff);

   // oldest spread sits n places behind the write pointer
   assign ram_rd_addr = ptr_ff - n[RING_AW-1:0];
   assign ram_rd_en   = (state_ff == ST_IDLE) && in_valid;
   assign ram_wr_en   = (state_ff == ST_SQ_NEW);

   // multiplier operand selection
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_SQ_NEW: begin
            op_a = spread_mag;
            op_b = spread_mag;
         end
         ST_SQ_OLD: begin
            op_a = old_mag;
            op_b = old_mag;
         end
         ST_N_SPREAD: begin
            op_a = MUL_W'(n);
            op_b = spread_mag;
         end
         ST_SUM_SQ: begin
            op_a = tot_mag;
            op_b = tot_mag;
         end
         ST_N_SQ_LO: begin
            op_a = MUL_W'(n);
            op_b = sq_ff[MUL_W-1:0];
         end
         ST_N_SQ_HI: begin
            op_a = MUL_W'(n);
            op_b = MUL_W'(sq_ff[SQUARE_W-1:MUL_W]);
         end
         ST_D_SQ: begin
            op_a = d_mag[MUL_W-1:0];
            op_b = d_mag[MUL_W-1:0];
         end
         ST_T_SQ: begin
            op_a = MUL_W'(cfg.threshold);
            op_b = MUL_W'(cfg.threshold);
         end
         ST_V_LO: begin
            op_a = v_ff[MUL_W-1:0];
            op_b = prod[MUL_W-1:0];
         end
         ST_V_HI: begin
            op_a = v_ff[PROD_W-1:MUL_W];
            op_b = t2_ff;
         end
         ST_CLOSE_MUL: begin
            op_a = units_mag;
            op_b = spread_mag;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // arithmetic around the product
   assign n_spread   = spread_ff[SPREAD_W-1] ? -$signed({2'b00, prod[MUL_W-1:0]})
                                             :  $signed({2'b00, prod[MUL_W-1:0]});
   assign d_wide     = n_spread - (TOTAL_W+2)'(tot_ff);
   assign ticks_inc  = {1'b0, ticks_ff} + 1'b1;
   assign ticks_cap  = {1'b0, n} + 1'b1;
   assign units_wide = (UNITS_W+1)'(units_ff);
   assign lim_wide   = $signed({2'b00, cfg.limit});
   assign sell_ok    = beyond_ff && !d_ff[TOTAL_W] && (units_wide > -lim_wide);
   assign buy_ok     = beyond_ff && d_ff[TOTAL_W] && (units_wide < lim_wide);
   assign trade_delta = sell_ok ? PROFIT_W'(spread_ff) : -PROFIT_W'(spread_ff);
   assign trade_sum  = sat_add(cash_ff, trade_delta);
   assign close_mag  = $signed({1'b0, prod[PROFIT_W-2:0]});
   assign close_delta = (units_ff[UNITS_W-1] ^ spread_ff[SPREAD_W-1]) ? -close_mag
                                                                      :  close_mag;
   assign close_sum  = sat_add(cash_ff, close_delta);
   assign lhs_wide   = {16'b0, lhs_ff, 16'b0};

   // sequencer next state and datapath
   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      tot_in    = tot_ff;
      sq_in     = sq_ff;
      ticks_in  = ticks_ff;
      units_in  = units_ff;
      cash_in   = cash_ff;
      clip_in   = clip_ff;
      order_in  = order_ff;
      spread_in = spread_ff;
      old_in    = old_ff;
      last_in   = last_ff;
      active_in = active_ff;
      d_in      = d_ff;
      sm2_in    = sm2_ff;
      v_in      = v_ff;
      lhs_in    = lhs_ff;
      t2_in     = t2_ff;
      rhs_in    = rhs_ff;
      beyond_in = beyond_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               spread_in = $signed({1'b0, price_a}) - $signed({1'b0, price_b});
               last_in   = last_tick;
               active_in = (ticks_ff >= n);
               order_in  = ORDER_NONE;
               state_in  = ST_SQ_NEW;
            end
         end
         ST_SQ_NEW: begin
            old_in   = active_ff ? $signed(ram_rd_data) : '0;
            state_in = ST_SQ_OLD;
         end
         ST_SQ_OLD: begin
            sq_in    = sq_ff + prod[SQUARE_W-1:0];
            tot_in   = tot_ff - TOTAL_W'(old_ff) + TOTAL_W'(spread_ff);
            state_in = ST_N_SPREAD;
         end
         ST_N_SPREAD: begin
            sq_in    = sq_ff - prod[SQUARE_W-1:0];
            ptr_in   = ptr_ff + 1'b1;
            ticks_in = (ticks_inc > ticks_cap) ? ticks_cap[WIN_W-1:0]
                                               : ticks_inc[WIN_W-1:0];
            if (active_ff) begin
               state_in = ST_SUM_SQ;
            end else if (last_ff) begin
               state_in = ST_CLOSE_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SUM_SQ: begin
            d_in     = d_wide[TOTAL_W:0];
            state_in = ST_N_SQ_LO;
         end
         ST_N_SQ_LO: begin
            sm2_in   = prod;
            state_in = ST_N_SQ_HI;
         end
         ST_N_SQ_HI: begin
            v_in     = prod - sm2_ff;
            state_in = ST_D_SQ;
         end
         ST_D_SQ: begin
            v_in     = v_ff + {prod[MUL_W-1:0], {MUL_W{1'b0}}};
            state_in = ST_T_SQ;
         end
         ST_T_SQ: begin
            lhs_in   = prod;
            state_in = ST_V_LO;
         end
         ST_V_LO: begin
            t2_in    = prod[MUL_W-1:0];
            state_in = ST_V_HI;
         end
         ST_V_HI: begin
            rhs_in   = {{MUL_W{1'b0}}, prod};
            state_in = ST_RHS;
         end
         ST_RHS: begin
            rhs_in   = rhs_ff + {prod, {MUL_W{1'b0}}};
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            beyond_in = (d_ff != '0) && (lhs_wide > rhs_ff);
            state_in  = ST_TRADE;
         end
         ST_TRADE: begin
            if (sell_ok || buy_ok) begin
               order_in = sell_ok ? ORDER_SELL : ORDER_BUY;
               units_in = sell_ok ? units_ff - 1'b1 : units_ff + 1'b1;
               cash_in  = trade_sum[PROFIT_W-1:0];
               clip_in  = clip_ff | trade_sum[PROFIT_W];
            end
            state_in = last_ff ? ST_CLOSE_MUL : ST_DONE;
         end
         ST_CLOSE_MUL: begin
            state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            cash_in  = close_sum[PROFIT_W-1:0];
            clip_in  = clip_ff | close_sum[PROFIT_W];
            units_in = '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // window register rewrite drops the history
      if (cfg.clear) begin
         ptr_in   = '0;
         tot_in   = '0;
         sq_in    = '0;
         ticks_in = '0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
         tot_ff   <= '0;
         sq_ff    <= '0;
         ticks_ff <= '0;
         units_ff <= '0;
         cash_ff  <= '0;
         clip_ff  <= 1'b0;
         order_ff <= ORDER_NONE;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         tot_ff   <= tot_in;
         sq_ff    <= sq_in;
         ticks_ff <= ticks_in;
         units_ff <= units_in;
         cash_ff  <= cash_in;
         clip_ff  <= clip_in;
         order_ff <= order_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      spread_ff <= spread_in;
      old_ff    <= old_in;
      last_ff   <= last_in;
      active_ff <= active_in;
      d_ff      <= d_in;
      sm2_ff    <= sm2_in;
      v_ff      <= v_in;
      lhs_ff    <= lhs_in;
      t2_ff     <= t2_in;
      rhs_ff    <= rhs_in;
      beyond_ff <= beyond_in;
   end

   // handshake and result
   assign in_ready  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   assign result.order            = order_ff;
   assign result.held_units       = units_ff;
   assign result.profit           = cash_ff;
   assign result.active           = active_ff;
   assign result.profit_saturated = clip_ff;

endmodule

[hdl/rolling_zscore_pair_trader_unit.sv]
// top level: register file, tick core and result register of the pair trader
`timescale 1ns / 1ps

// channel  direction  transaction                 payload
// req      in         one tick of two prices      tdata price_a, price_b; tlast last_tick
// rsp      out        one result per tick         tdata order .. profit_saturated
// csr      in         one register write          csr_addr index, csr_wdata value
//
// A tick runs the window upkeep steps while the window fills, adds the z-score
// test and trading once trading is evaluated, and a square-off on a last tick; the
// single 32x32 multiplier, used up to eleven times per tick, serves them all in turn.
// Synchronous active-high reset restores the register defaults, empties the window
// and clears position and profit. A result waits in its own register, so the next
// tick is taken while rsp is stalled; the core holds only if that register is full.
module rolling_zscore_pair_trader_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rzpt_pkg::REQ_DATA_W-1:0] req_tdata,   // price_a, price_b
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // order, held_units, profit, active, profit_saturated, zero pad
   output logic [rzpt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rzpt_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [rzpt_pkg::CSR_DW-1:0]     csr_wdata
);

   import rzpt_pkg::*;

   logic [WIN_W-1:0]   window_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [THR_W-1:0]   thr_ff;
   logic               csr_write;
   cfg_type            cfg;
   logic               res_valid;
   logic               res_ready;
   result_type         result;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // window value as the core uses it
   function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] res;
      if (w == '0) begin
         res = WIN_W'(1);
      end else if (32'(w) > MAX_WINDOW) begin
         res = WIN_W'(MAX_WINDOW);
      end else begin
         res = w;
      end
      return res;
   endfunction

   // register writes
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         limit_ff  <= LIMIT_RESET;
         thr_ff    <= THRESHOLD_RESET;
      end else if (csr_write) begin
         case (csr_addr)
            REG_WINDOW:    window_ff <= csr_wdata[WIN_W-1:0];
            REG_LIMIT:     limit_ff  <= csr_wdata[LIMIT_W-1:0];
            REG_THRESHOLD: thr_ff    <= csr_wdata[THR_W-1:0];
            default:       ;
         endcase
      end
   end

   assign cfg.window    = eff_window(window_ff);
   assign cfg.limit     = limit_ff;
   assign cfg.threshold = thr_ff;
   assign cfg.clear     = csr_write && (csr_addr == REG_WINDOW);

   rzpt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .price_a   (req_tdata[PRICE_W-1:0]),
      .price_b   (req_tdata[REQ_DATA_W-1:PRICE_W]),
      .last_tick (req_tlast),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .result    (result)
   );

   // result register between core and rsp channel
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= {1'b0, result.profit_saturated, result.active, result.profit,
                         result.held_units, result.order};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sim/rolling_zscore_pair_trader_unit_tb.sv]
// self-checking testbench: directed and random price ticks checked against a trader predictor
`timescale 1ns / 1ps

module rolling_zscore_pair_trader_unit_tb;
   import rzpt_pkg::*;

   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;

   // result field positions in rsp_tdata, lowest first
   localparam int HELD_LSB   = ORDER_W;
   localparam int PROFIT_LSB = HELD_LSB + UNITS_W;
   localparam int ACTIVE_BIT = PROFIT_LSB + PROFIT_W;
   localparam int CLIP_BIT   = ACTIVE_BIT + 1;

   localparam logic [PRICE_W-1:0] PRICE_TOP = '1;

   typedef struct {
      order_type                  order;
      logic signed [UNITS_W-1:0]  held;
      logic signed [PROFIT_W-1:0] profit;
      logic                       active;
      logic                       clipped;
   } tick_outcome_type;

   // predicts each tick outcome and checks the rsp transactions against it
   class pair_trade_tracker_type;
      logic [WIN_W-1:0]           window_reg    = WINDOW_RESET;
      logic [LIMIT_W-1:0]         limit_reg     = LIMIT_RESET;
      logic [THR_W-1:0]           threshold_reg = THRESHOLD_RESET;
      logic signed [SPREAD_W-1:0] spread_ring [MAX_WINDOW];
      int unsigned                ring_ptr      = 0;
      longint                     spread_sum    = 0;
      longint                     square_sum    = 0;
      int unsigned                ticks_filled  = 0;
      int                         units         = 0;
      longint                     cash          = 0;
      bit                         clipped       = 0;
      int                         mismatches    = 0;
      tick_outcome_type           predicted_outcomes [$];

      function void write_register(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] wdata);
         case (addr)
            REG_WINDOW: begin
               // new window length drops the spread history, position and cash stay
               window_reg   = wdata[WIN_W-1:0];
               ring_ptr     = 0;
               spread_sum   = 0;
               square_sum   = 0;
               ticks_filled = 0;
            end
            REG_LIMIT:     limit_reg = wdata[LIMIT_W-1:0];
            REG_THRESHOLD: threshold_reg = wdata[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function void book_profit(longint delta);
         longint total;
         total = cash + delta;
         if (total > longint'(PROFIT_MAX)) begin
            total   = longint'(PROFIT_MAX);
            clipped = 1'b1;
         end
         if (total < longint'(PROFIT_MIN)) begin
            total   = longint'(PROFIT_MIN);
            clipped = 1'b1;
         end
         cash = total;
      endfunction

      function void note_tick(logic [PRICE_W-1:0] price_a, logic [PRICE_W-1:0] price_b,
                              bit last);
         longint           spread, stale, gap, gap_mag, sum_mag;
         int unsigned      n, prior, oldest;
         int               lim;
         logic [127:0]     variance, lhs, rhs;
         bit               active, beyond;
         tick_outcome_type outcome;
         n = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg;
         spread = longint'(price_a) - longint'(price_b);
         prior  = ticks_filled;
         active = prior >= n;
         lim    = int'(limit_reg);
         outcome.order = ORDER_NONE;

         // slide the window so that it covers the last n spreads, this one included
         if (active) begin
            oldest     = (ring_ptr + MAX_WINDOW - n) % MAX_WINDOW;
            stale      = longint'(spread_ring[oldest]);
            spread_sum -= stale;
            square_sum -= stale * stale;
         end
         spread_ring[ring_ptr] = spread[SPREAD_W-1:0];
         ring_ptr     = (ring_ptr + 1) % MAX_WINDOW;
         spread_sum   += spread;
         square_sum   += spread * spread;
         ticks_filled = (prior + 1 > n + 1) ? n + 1 : prior + 1;

         // z-score test squared: 65536*D^2 against threshold^2 * V
         if (active) begin
            gap      = longint'(n) * spread - spread_sum;
            gap_mag  = (gap < 0) ? -gap : gap;
            sum_mag  = (spread_sum < 0) ? -spread_sum : spread_sum;
            variance = 128'(n) * 128'(square_sum) - 128'(sum_mag) * 128'(sum_mag);
            rhs      = variance * (128'(threshold_reg) * 128'(threshold_reg));
            lhs      = (128'(gap_mag) * 128'(gap_mag)) << 16;
            beyond   = (gap != 0) && (lhs > rhs);
            if (beyond && gap > 0 && units > -lim) begin
               outcome.order = ORDER_SELL;
               units--;
               book_profit(spread);
            end else if (beyond && gap < 0 && units < lim) begin
               outcome.order = ORDER_BUY;
               units++;
               book_profit(-spread);
            end
         end

         // square-off, short and long alike
         if (last) begin
            book_profit(longint'(units) * spread);
            units = 0;
         end

         outcome.held    = units[UNITS_W-1:0];
         outcome.profit  = cash[PROFIT_W-1:0];
         outcome.active  = active;
         outcome.clipped = clipped;
         predicted_outcomes.insert(predicted_outcomes.size(), outcome);
      endfunction

      function void check_outcome(logic [RSP_DATA_W-1:0] tdata);
         tick_outcome_type           want;
         logic [ORDER_W-1:0]         got_order;
         logic signed [UNITS_W-1:0]  got_held;
         logic signed [PROFIT_W-1:0] got_profit;
         if (predicted_outcomes.size() == 0) begin
            $error("rsp transaction with no tick waiting, tdata %h", tdata);
            mismatches++;
            return;
         end
         want       = predicted_outcomes.pop_front();
         got_order  = tdata[ORDER_W-1:0];
         got_held   = tdata[PROFIT_LSB-1:HELD_LSB];
         got_profit = tdata[ACTIVE_BIT-1:PROFIT_LSB];
         if (got_order != want.order) begin
            $error("order expected %0d actual %0d", want.order, got_order);
            mismatches++;
         end
         if (got_held != want.held) begin
            $error("held_units expected %0d actual %0d", want.held, got_held);
            mismatches++;
         end
         if (got_profit != want.profit) begin
            $error("profit expected %0d actual %0d", want.profit, got_profit);
            mismatches++;
         end
         if (tdata[ACTIVE_BIT] != want.active) begin
            $error("active expected %0d actual %0d", want.active, tdata[ACTIVE_BIT]);
            mismatches++;
         end
         if (tdata[CLIP_BIT] != want.clipped) begin
            $error("profit_saturated expected %0d actual %0d", want.clipped, tdata[CLIP_BIT]);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic [CSR_AW-1:0]     csr_addr   = '0;
   logic [CSR_DW-1:0]     csr_wdata  = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_ready;

   int req_idle_pct = 18;
   int rsp_idle_pct = 73;
   int hold_left    = 0;
   int quiet_cycles = 0;
   int spread_drift = 0;
   int mid_price    = 8000000;

   pair_trade_tracker_type tracker = new;

   rolling_zscore_pair_trader_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: every transaction goes to the tracker
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_register(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) begin
            tracker.note_tick(req_tdata[PRICE_W-1:0], req_tdata[REQ_DATA_W-1:PRICE_W],
                              req_tlast);
         end
         if (rsp_tvalid && rsp_tready) tracker.check_outcome(rsp_tdata);
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // watchdog on cycles with no transaction at all
   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("rolling_zscore_pair_trader_unit regression: fail");
      $finish;
   end

   function automatic logic [PRICE_W-1:0] clip_price(longint v);
      if (v < 0) return '0;
      if (v > longint'(PRICE_TOP)) return PRICE_TOP;
      return v[PRICE_W-1:0];
   endfunction

   // one register write; the caller lowers csr_valid after the last one
   task automatic write_csr(input logic [CSR_AW-1:0] addr, input int value, input int width);
      logic [CSR_DW-1:0] keep;
      keep = CSR_DW'((64'd1 << width) - 1);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= (CSR_DW'(value) & keep) | (CSR_DW'($urandom) & ~keep);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_settings(input int window, input int limit, input int threshold);
      write_csr(REG_WINDOW, window, WIN_W);
      write_csr(REG_LIMIT, limit, LIMIT_W);
      write_csr(REG_THRESHOLD, threshold, THR_W);
      csr_valid <= 1'b0;
   endtask

   task automatic send_tick(input logic [PRICE_W-1:0] price_a,
                            input logic [PRICE_W-1:0] price_b, input bit last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {price_b, price_a};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.predicted_outcomes.size() != 0);
   endtask

   // mostly a mean-reverting spread with spikes, some raw and edge prices
   task automatic make_tick(output logic [PRICE_W-1:0] price_a,
                            output logic [PRICE_W-1:0] price_b, output bit last);
      int     pick, spike;
      longint level_b;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         price_a = PRICE_W'($urandom);
         price_b = PRICE_W'($urandom);
      end else if (pick < 18) begin
         price_a = ($urandom_range(0, 1) != 0) ? PRICE_TOP : '0;
         price_b = ($urandom_range(0, 1) != 0) ? PRICE_TOP : '0;
      end else begin
         spread_drift = spread_drift - spread_drift / 8 + int'($urandom_range(0, 4000)) - 2000;
         mid_price    = mid_price + int'($urandom_range(0, 2000)) - 1000;
         if (mid_price < 100000) mid_price = 100000;
         if (mid_price > 16000000) mid_price = 16000000;
         spike = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 100000)) - 50000 : 0;
         level_b = longint'(mid_price) + int'($urandom_range(0, 200)) - 100;
         price_b = clip_price(level_b);
         price_a = clip_price(level_b + spread_drift + spike + int'($urandom_range(0, 60)) - 30);
      end
      last = ($urandom_range(0, 39) == 0);
   endtask

   task automatic run_phase(input int window, input int limit, input int threshold,
                            input int count, input int hold);
      logic [PRICE_W-1:0] price_a, price_b;
      bit                 last;
      program_settings(window, limit, threshold);
      if (hold > 0) hold_left = hold;
      repeat (count) begin
         make_tick(price_a, price_b, last);
         send_tick(price_a, price_b, last);
      end
      drain_results;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme prices, flat window, limit reached, square-off both ways
      program_settings(2, 2, 0);
      send_tick('0, '0, 1'b0);
      send_tick(PRICE_TOP, '0, 1'b0);
      send_tick('0, PRICE_TOP, 1'b0);
      send_tick('0, PRICE_TOP, 1'b0);
      send_tick(24'd1000, '0, 1'b0);
      send_tick(24'd2000, '0, 1'b0);
      send_tick(24'd3000, '0, 1'b0);
      send_tick(24'd4000, '0, 1'b0);
      send_tick(24'd5000, '0, 1'b1);
      send_tick(PRICE_TOP, PRICE_TOP, 1'b0);
      send_tick(24'd100, 24'd300, 1'b0);
      send_tick(24'd50, 24'd400, 1'b0);
      drain_results;

      // limit lowered below the held position: only reducing orders pass
      program_settings(2, 1, 0);
      send_tick(24'd10, 24'd100, 1'b0);
      send_tick(24'd10, 24'd300, 1'b0);
      send_tick(24'd10, 24'd500, 1'b0);
      send_tick(24'd900, 24'd10, 1'b0);
      drain_results;

      // window length zero behaves as one, then a long square-off
      program_settings(0, 3, 0);
      send_tick(24'd5, 24'd3, 1'b0);
      send_tick(24'd7, 24'd1, 1'b0);
      send_tick(24'd2, 24'd9, 1'b1);
      drain_results;

      // light sender gaps, heavy receiver stalls, one long hold-off
      req_idle_pct = 18;
      rsp_idle_pct = 73;
      run_phase(20, 5, 512, 150, 0);
      run_phase(64, 1023, 0, 200, HOLD_CYCLES);
      run_phase(127, 10, 256, 150, 0);

      // heavy sender gaps, light receiver stalls
      req_idle_pct = 73;
      rsp_idle_pct = 18;
      run_phase(1, 0, 100, 100, 0);
      run_phase(8, 3, 384, 150, 0);
      run_phase(65, 20, 65535, 100, 0);

      // back to back
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_phase(3, 1023, 0, 250, 0);
      run_phase(16, 7, 200, 200, 0);
      run_phase(2, 4, 700, 300, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.predicted_outcomes.size() == 0) begin
         $display("rolling_zscore_pair_trader_unit regression: pass");
      end else begin
         $display("rolling_zscore_pair_trader_unit regression: fail");
      end
      $finish;
   end

endmodule
